// ----- hdl/growing_block_pool_slot_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// Slot allocator assertion macros
// Shared forms for the concurrent checks of the slot allocator. Each check is
// clocked on clk and is switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GROWING_BLOCK_POOL_SLOT_ALLOCATOR_MACROS_SVH
`define GROWING_BLOCK_POOL_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define GBPSA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GBPSA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/gbpsa_pkg.sv -----
// ----------------------------------------------------------------------------
// Slot allocator package
// Sizes, codes, handle type and the control structs shared by the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbpsa_pkg;

	localparam int BASE_BLOCK = 16;
	localparam int MAX_BLOCKS = 8;
	localparam int FREE_DEPTH = 2048;

	localparam int REQ_W    = 2;
	localparam int STATUS_W = 2;
	localparam int BLK_W    = 3;
	localparam int ELEM_W   = 10;

	// The largest block holds BASE_BLOCK << (MAX_BLOCKS - 2) slots, and a
	// taken count must be able to reach that size.
	localparam int COUNT_W     = $clog2(BASE_BLOCK << (MAX_BLOCKS - 2)) + 1;
	localparam int OPEN_W      = $clog2(MAX_BLOCKS + 1);
	localparam int FREE_ADDR_W = $clog2(FREE_DEPTH);
	localparam int FREE_CNT_W  = $clog2(FREE_DEPTH + 1);

	typedef enum logic [REQ_W-1:0] {
		REQ_TAKE   = 2'd0,
		REQ_RETURN = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_RESET  = 2'd3
	} req_code_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_NO_SPACE   = 2'd1,
		ST_BAD_RETURN = 2'd2
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_POP  = 1'b1
	} state_t;

	typedef struct packed {
		logic [BLK_W-1:0]  blk;
		logic [ELEM_W-1:0] elem;
	} handle_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} stack_cmd_t;

	typedef struct packed {
		logic             bump;
		logic             inc;
		logic [BLK_W-1:0] inc_block;
		logic             dec;
		logic             clear;
		logic             reset_open;
	} table_cmd_t;

	typedef struct packed {
		logic              bump_ok;
		logic [BLK_W-1:0]  bump_block;
		logic [ELEM_W-1:0] bump_element;
		logic              ret_ok;
	} table_status_t;

	// Slots in block k: blocks 0 and 1 hold BASE_BLOCK, each later one doubles.
	function automatic logic [COUNT_W-1:0] block_size(input logic [BLK_W-1:0] k);
		logic [COUNT_W-1:0] base;
		base = COUNT_W'(BASE_BLOCK);
		if (k == '0) begin
			return base;
		end
		return base << (k - 1'b1);
	endfunction

endpackage

`default_nettype wire

// ----- hdl/gbpsa_ifs.sv -----
// ----------------------------------------------------------------------------
// Slot allocator channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gbpsa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [2:0]  ret_block;
	logic [9:0]  ret_element;

	modport source (output valid, output req_type, output ret_block, output ret_element,
		input ready);
	modport sink (input valid, input req_type, input ret_block, input ret_element,
		output ready);
endinterface

interface gbpsa_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [2:0]  got_block;
	logic [9:0]  got_element;

	modport source (output valid, output status, output got_block, output got_element,
		input ready);
	modport sink (input valid, input status, input got_block, input got_element,
		output ready);
endinterface

`default_nettype wire

// ----- hdl/gbpsa_free_stack.sv -----
// ----------------------------------------------------------------------------
// Free handle stack
// Synchronous memory of returned handles with its fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbpsa_free_stack import gbpsa_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire stack_cmd_t            cmd,
	input  wire handle_t               push_handle,
	output handle_t                    pop_handle,
	output logic [FREE_CNT_W-1:0]      count
);

	handle_t                 mem [FREE_DEPTH];
	handle_t                 rd_q;
	logic [FREE_CNT_W-1:0]   count_q;
	logic [FREE_ADDR_W-1:0]  wr_addr;
	logic [FREE_ADDR_W-1:0]  rd_addr;

	assign wr_addr = count_q[FREE_ADDR_W-1:0];
	assign rd_addr = FREE_ADDR_W'(count_q - 1'b1);

	// Entries are only read below the fill count, so they need no clearing.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_addr] <= push_handle;
		end
		if (cmd.pop) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.pop) begin
			count_q <= count_q - 1'b1;
		end
	end

	assign pop_handle = rd_q;
	assign count      = count_q;

endmodule

`default_nettype wire

// ----- hdl/gbpsa_block_table.sv -----
// ----------------------------------------------------------------------------
// Block table
// Taken count of every block, the number of open blocks, the newest-first
// scan for a block with room and the checks on a returned handle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbpsa_block_table import gbpsa_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire table_cmd_t        cmd,
	input  wire logic [BLK_W-1:0]  ret_block,
	input  wire logic [ELEM_W-1:0] ret_element,
	output table_status_t          status
);

	logic [COUNT_W-1:0]    taken_q [MAX_BLOCKS];
	logic [OPEN_W-1:0]     open_q;
	logic [MAX_BLOCKS-1:0] is_open;
	logic [MAX_BLOCKS-1:0] not_full;
	logic [MAX_BLOCKS-1:0] nonzero;
	logic                  hit;
	logic [BLK_W-1:0]      sel;
	logic                  can_open;
	logic [BLK_W-1:0]      new_block;

	// Per-block flags; the scan keeps the highest open block with room.
	always_comb begin
		hit = 1'b0;
		sel = '0;
		for (int b = 0; b < MAX_BLOCKS; b++) begin
			is_open[b]  = OPEN_W'(b) < open_q;
			not_full[b] = taken_q[b] < block_size(BLK_W'(b));
			nonzero[b]  = taken_q[b] != '0;
			if (is_open[b] && not_full[b]) begin
				hit = 1'b1;
				sel = BLK_W'(b);
			end
		end
	end

	assign can_open  = open_q < OPEN_W'(MAX_BLOCKS);
	assign new_block = open_q[BLK_W-1:0];

	always_comb begin
		status.bump_ok      = hit || can_open;
		status.bump_block   = hit ? sel : new_block;
		status.bump_element = hit ? ELEM_W'(taken_q[sel]) : '0;
		status.ret_ok       = is_open[ret_block] && nonzero[ret_block] &&
			(COUNT_W'(ret_element) < block_size(ret_block));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < MAX_BLOCKS; b++) begin
				taken_q[b] <= '0;
			end
			open_q <= OPEN_W'(1);
		end else if (cmd.clear) begin
			for (int b = 0; b < MAX_BLOCKS; b++) begin
				taken_q[b] <= '0;
			end
			if (cmd.reset_open) begin
				open_q <= OPEN_W'(1);
			end
		end else begin
			for (int b = 0; b < MAX_BLOCKS; b++) begin
				if (cmd.bump && hit && sel == BLK_W'(b)) begin
					taken_q[b] <= taken_q[b] + 1'b1;
				end else if (cmd.bump && !hit && can_open && new_block == BLK_W'(b)) begin
					taken_q[b] <= COUNT_W'(1);
				end else if (cmd.inc && cmd.inc_block == BLK_W'(b)) begin
					taken_q[b] <= taken_q[b] + 1'b1;
				end else if (cmd.dec && ret_block == BLK_W'(b)) begin
					taken_q[b] <= taken_q[b] - 1'b1;
				end
			end
			if (cmd.bump && !hit && can_open) begin
				open_q <= open_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/growing_block_pool_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// Growing block pool slot allocator
// Hands out (block, element) slot handles from geometrically growing blocks,
// reusing returned handles first through a stack held in synchronous memory.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Payload                              | Handshake
//   --------+-----------+--------------------------------------+-------------
//   req     | in        | req_type, ret_block, ret_element     | valid/ready
//   rsp     | out       | status, got_block, got_element       | valid/ready
//
// Every request gives exactly one response. A take served from the free
// stack passes through the pop wait state, since the stack memory registers its
// read data behind the address; every other request is answered directly.
// arst_n empties the stack, zeroes all taken counts and leaves only block 0
// open. The stack memory itself is not cleared, as only filled entries are read.
// A response waits in an output register; a new request is taken in the same
// cycle as that response transfers, and held off while it is stalled or a pop waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "growing_block_pool_slot_allocator_macros.svh"

module growing_block_pool_slot_allocator import gbpsa_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	gbpsa_req_if.sink    req,
	gbpsa_rsp_if.source  rsp
);

	state_t                 state_q;
	state_t                 state_d;
	logic                   accept;
	req_code_t              req_code;
	stack_cmd_t             stack_cmd;
	table_cmd_t             table_cmd;
	table_status_t          tbl;
	handle_t                push_handle;
	handle_t                pop_handle;
	logic [FREE_CNT_W-1:0]  free_count;
	logic                   stack_empty;
	logic                   stack_full;

	logic                   rsp_load;
	status_t                status_d;
	logic [BLK_W-1:0]       block_d;
	logic [ELEM_W-1:0]      element_d;
	logic                   rsp_valid_q;
	status_t                rsp_status_q;
	logic [BLK_W-1:0]       rsp_block_q;
	logic [ELEM_W-1:0]      rsp_element_q;

	// New requests are taken only between operations, and only when the
	// output register is empty or is handing its response over right now.
	assign req.ready = (state_q == FSM_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign req_code  = req_code_t'(req.req_type);

	assign stack_empty = (free_count == '0);
	assign stack_full  = (free_count == FREE_CNT_W'(FREE_DEPTH));

	assign push_handle.blk  = req.ret_block;
	assign push_handle.elem = req.ret_element;

	// A push writes the stack at one accept edge and a pop can read it no
	// earlier than the next accept edge, so reads always see the new entry.
	gbpsa_free_stack u_free_stack (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (stack_cmd),
		.push_handle (push_handle),
		.pop_handle  (pop_handle),
		.count       (free_count)
	);

	gbpsa_block_table u_block_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (table_cmd),
		.ret_block   (req.ret_block),
		.ret_element (req.ret_element),
		.status      (tbl)
	);

	// Next state: only a take that finds handles on the stack waits in FSM_POP
	// for the memory read.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept && req_code == REQ_TAKE && !stack_empty) begin
					state_d = FSM_POP;
				end
			end
			FSM_POP: begin
				state_d = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// Commands to the stack and the block table, and the response to load.
	always_comb begin
		stack_cmd = '0;
		table_cmd = '0;
		rsp_load  = 1'b0;
		status_d  = ST_OK;
		block_d   = '0;
		element_d = '0;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					unique case (req_code)
						REQ_TAKE: begin
							if (!stack_empty) begin
								stack_cmd.pop = 1'b1;
							end else begin
								// Bump allocation in the newest block with room,
								// or in a freshly opened block.
								table_cmd.bump = 1'b1;
								rsp_load       = 1'b1;
								if (tbl.bump_ok) begin
									block_d   = tbl.bump_block;
									element_d = tbl.bump_element;
								end else begin
									status_d = ST_NO_SPACE;
								end
							end
						end
						REQ_RETURN: begin
							rsp_load = 1'b1;
							if (tbl.ret_ok && !stack_full) begin
								stack_cmd.push = 1'b1;
								table_cmd.dec  = 1'b1;
							end else begin
								status_d = ST_BAD_RETURN;
							end
						end
						REQ_CLEAR: begin
							rsp_load        = 1'b1;
							stack_cmd.clear = 1'b1;
							table_cmd.clear = 1'b1;
						end
						REQ_RESET: begin
							rsp_load             = 1'b1;
							stack_cmd.clear      = 1'b1;
							table_cmd.clear      = 1'b1;
							table_cmd.reset_open = 1'b1;
						end
						default: begin
							rsp_load = 1'b0;
						end
					endcase
				end
			end
			FSM_POP: begin
				// The popped handle is live again in its block.
				rsp_load            = 1'b1;
				table_cmd.inc       = 1'b1;
				table_cmd.inc_block = pop_handle.blk;
				block_d             = pop_handle.blk;
				element_d           = pop_handle.elem;
			end
			default: begin
				rsp_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q  <= status_d;
			rsp_block_q   <= block_d;
			rsp_element_q <= element_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.got_block   = rsp_block_q;
	assign rsp.got_element = rsp_element_q;

	// A pop is only ever issued while the stack holds handles.
	`GBPSA_ASSERT_IMP(a_pop_not_empty, stack_cmd.pop, free_count != '0, "pop on empty stack")
	// The response register is free while a popped handle is on its way.
	`GBPSA_ASSERT_IMP(a_pop_rsp_free, state_q == FSM_POP, !rsp_valid_q, "response register busy during pop")
	// Every request that is not a pop has its response valid in the next cycle.
	`GBPSA_ASSERT_NXT(a_rsp_follows, accept && !stack_cmd.pop, rsp_valid_q, "response missing after request")
	// The pop wait state always returns to idle in the following cycle.
	`GBPSA_ASSERT_NXT(a_pop_one_cycle, state_q == FSM_POP, state_q == FSM_IDLE, "pop wait too long")

endmodule

`default_nettype wire
